/* rtl/lfu_cache_table_defines.svh */
// ----------------------------------------------------------------------------
// LFU cache table assertion macros
// Shared property shapes for the cache table checks.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_TABLE_DEFINES_SVH
`define LFU_CACHE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define LCT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lct_pkg.sv */
// ----------------------------------------------------------------------------
// LFU cache table package
// Widths, defaults and operation codes of the cache table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lct_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int COUNT_BITS_DEF = 16;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  typedef enum logic {
    ACT_GET = 1'b0,
    ACT_PUT = 1'b1
  } action_t;

endpackage

/* rtl/lfu_cache_table.sv */
// ----------------------------------------------------------------------------
// LFU cache table
// Key/value cache with least-frequently-used replacement and recency ties.
// ----------------------------------------------------------------------------
// The table takes one get or put word per clock and returns one result word
// for each accepted word: the input register captures the word, and the
// lookup stage then looks it up, updates the table and registers the result,
// which is then shown with out_valid high for exactly one cycle. The receiver
// cannot stall, so busy is always low and a new word may be started on every
// clock. The one-per-cycle rate is set by the lookup cycle: a parallel key
// compare against every entry and a registered-to-registered victim search
// (a binary tree over use count and recency) both complete in that cycle,
// and the table update of one word is visible to the word right behind it.
// A get counts a use and returns the stored value, or all ones on a miss.
// A put updates a present key or inserts a new one with count one, evicting
// the least used entry (oldest in its count class) once the live entries
// reach the capacity. Capacity above the table size acts as the table size;
// capacity zero makes puts return an all-zero result and change nothing.
// The capacity register accepts a write every cycle (cfg_ready is high) and
// must only be written while no word is in flight. Use counts saturate.
`timescale 1ns / 1ps

`include "lfu_cache_table_defines.svh"

module lfu_cache_table
  import lct_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Command side.
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_action,
  input  logic signed [KEY_W-1:0]  in_key,
  input  logic signed [DATA_W-1:0] in_value,
  // Result side.
  output logic                     out_valid,
  output logic                     out_hit,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic                     out_evicted,
  output logic signed [KEY_W-1:0]  out_evicted_key,
  // Capacity register write channel.
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CAP_W-1:0]         cfg_capacity
);

  // Index, rank and live-count widths follow from the table size; COUNT_BITS sets the use count width.
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int P      = 1 << IDX_W;
  localparam int LIVE_W = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (LIVE_W > CAP_W) ? LIVE_W : CAP_W;
  localparam int SK_W   = 1 + COUNT_BITS + RANK_W;

  localparam logic [CMP_W-1:0]      ENTRIES_CMP = CMP_W'(ENTRIES);
  localparam logic [COUNT_BITS-1:0] COUNT_ONE   = COUNT_BITS'(1);

  // Both handshakes are always open.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // --------------------------------------------------------------------------
  // Capacity register.
  // --------------------------------------------------------------------------
  logic [CAP_W-1:0] cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_capacity;
    end
  end

  // --------------------------------------------------------------------------
  // Input register: one word captured per accepted start.
  // --------------------------------------------------------------------------
  logic              s1_valid_r;
  action_t           s1_action_r;
  logic [KEY_W-1:0]  s1_key_r;
  logic [DATA_W-1:0] s1_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s1_action_r <= action_t'(in_action);
      s1_key_r    <= in_key;
      s1_value_r  <= in_value;
    end
  end

  // --------------------------------------------------------------------------
  // Table storage. Only the valid bits are reset; the rest is written on
  // insertion and never read while its entry is invalid.
  // --------------------------------------------------------------------------
  logic [ENTRIES-1:0]    valid_r;
  logic [KEY_W-1:0]      key_r   [ENTRIES];
  logic [DATA_W-1:0]     value_r [ENTRIES];
  logic [COUNT_BITS-1:0] count_r [ENTRIES];
  logic [RANK_W-1:0]     rank_r  [ENTRIES];

  // --------------------------------------------------------------------------
  // Lookup: key match, first free slot and live count.
  // --------------------------------------------------------------------------
  logic             hit;
  logic [IDX_W-1:0] found_idx;
  logic [IDX_W-1:0] free_idx;
  logic [LIVE_W-1:0] live;

  always_comb begin
    hit       = 1'b0;
    found_idx = '0;
    free_idx  = '0;
    live      = '0;
    // Scan from the top so that the lowest index wins.
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && (key_r[i] == s1_key_r)) begin
        hit       = 1'b1;
        found_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      live = live + LIVE_W'(valid_r[i]);
    end
  end

  // --------------------------------------------------------------------------
  // Victim search: a binary tree over {invalid, count, inverted rank}. The
  // smallest key wins, and on a full tie the left (lower index) side stays.
  // --------------------------------------------------------------------------
  logic [SK_W-1:0]  tk [IDX_W+1][P];
  logic [IDX_W-1:0] ti [IDX_W+1][P];
  logic [IDX_W-1:0] victim_idx;

  always_comb begin
    tk = '{default: '0};
    ti = '{default: '0};
    for (int n = 0; n < ENTRIES; n++) begin
      tk[0][n] = valid_r[n] ? {1'b0, count_r[n], ~rank_r[n]} : '1;
      ti[0][n] = IDX_W'(n);
    end
    for (int n = ENTRIES; n < P; n++) begin
      tk[0][n] = '1;
      ti[0][n] = IDX_W'(n);
    end
    for (int l = 0; l < IDX_W; l++) begin
      for (int n = 0; n < (P >> (l + 1)); n++) begin
        if (tk[l][2*n+1] < tk[l][2*n]) begin
          tk[l+1][n] = tk[l][2*n+1];
          ti[l+1][n] = ti[l][2*n+1];
        end else begin
          tk[l+1][n] = tk[l][2*n];
          ti[l+1][n] = ti[l][2*n];
        end
      end
    end
    victim_idx = ti[IDX_W][0];
  end

  // --------------------------------------------------------------------------
  // Decision for the word in the input register.
  // --------------------------------------------------------------------------
  logic [CMP_W-1:0]  cap_eff;
  logic              cap_zero;
  logic              is_put;
  logic              do_touch;
  logic              do_insert;
  logic              do_evict;
  logic [IDX_W-1:0]  slot_idx;
  logic [IDX_W-1:0]  sel_idx;
  logic [RANK_W-1:0] sel_rank;

  always_comb begin
    cap_eff   = (CMP_W'(cap_r) > ENTRIES_CMP) ? ENTRIES_CMP : CMP_W'(cap_r);
    cap_zero  = (cap_eff == '0);
    is_put    = (s1_action_r == ACT_PUT);
    do_touch  = s1_valid_r && hit && (!is_put || !cap_zero);
    do_insert = s1_valid_r && is_put && !cap_zero && !hit;
    do_evict  = do_insert && (CMP_W'(live) >= cap_eff);
    slot_idx  = do_evict ? victim_idx : free_idx;
    // A hit and an eviction never happen together, so one rank read serves.
    sel_idx   = hit ? found_idx : victim_idx;
    sel_rank  = rank_r[sel_idx];
  end

  // --------------------------------------------------------------------------
  // Table update.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (do_insert) begin
      valid_r[slot_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_touch) begin
        if (IDX_W'(i) == found_idx) begin
          if (count_r[i] != '1) begin
            count_r[i] <= count_r[i] + COUNT_ONE;
          end
          rank_r[i] <= '0;
          if (is_put) begin
            value_r[i] <= s1_value_r;
          end
        end else if (valid_r[i] && (rank_r[i] < sel_rank)) begin
          rank_r[i] <= rank_r[i] + RANK_W'(1);
        end
      end else if (do_insert) begin
        if (IDX_W'(i) == slot_idx) begin
          key_r[i]   <= s1_key_r;
          value_r[i] <= s1_value_r;
          count_r[i] <= COUNT_ONE;
          rank_r[i]  <= '0;
        end else if (valid_r[i] && !(do_evict && (rank_r[i] > sel_rank))) begin
          // Entries older than the victim close its gap and then age by one
          // for the new entry, which leaves them where they were.
          rank_r[i] <= rank_r[i] + RANK_W'(1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register.
  // --------------------------------------------------------------------------
  logic              out_valid_r;
  logic              out_hit_r;
  logic [DATA_W-1:0] out_read_value_r;
  logic              out_evicted_r;
  logic [KEY_W-1:0]  out_evicted_key_r;

  logic [DATA_W-1:0] read_value_nxt;
  logic [KEY_W-1:0]  evicted_key_nxt;

  always_comb begin
    if (is_put) begin
      read_value_nxt = '0;
    end else if (hit) begin
      read_value_nxt = value_r[found_idx];
    end else begin
      read_value_nxt = MISS_VALUE;
    end
    evicted_key_nxt = do_evict ? key_r[victim_idx] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      out_hit_r         <= hit && (!is_put || !cap_zero);
      out_read_value_r  <= read_value_nxt;
      out_evicted_r     <= do_evict;
      out_evicted_key_r <= evicted_key_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_read_value_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evicted_key_r;

  // --------------------------------------------------------------------------
  // Checks.
  // --------------------------------------------------------------------------
  `LCT_ASSERT_NEXT(a_result_follows_word, 1'b1, out_valid_r == $past(s1_valid_r),
    "result strobe does not follow the captured word")
  `LCT_ASSERT_SAME(a_evict_not_hit, out_valid_r && out_evicted_r, !out_hit_r,
    "eviction reported together with a hit")
  `LCT_ASSERT_SAME(a_victim_is_live, do_evict, valid_r[victim_idx],
    "eviction picked an empty entry")
  `LCT_ASSERT_SAME(a_fill_free_slot, do_insert && !do_evict, !valid_r[free_idx],
    "insertion without eviction overwrites a live entry")
  `LCT_ASSERT_NEXT(a_live_never_drops, 1'b1,
    $countones(valid_r) >= $past($countones(valid_r)),
    "live entry count decreased")

endmodule
